// ===== rtl/brainfuck_execute_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the execute core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BRAINFUCK_EXECUTE_CORE_ASSERT_SVH
`define BRAINFUCK_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever a holds, b holds too
`define BFX_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("execute core check failed");

// Next-cycle implication: whenever a holds, b holds in the next cycle
`define BFX_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("execute core check failed");

`else

`define BFX_ASSERT_IMP(label, clk, rst, a, b)
`define BFX_ASSERT_NXT(label, clk, rst, a, b)

`endif

`endif

// ===== rtl/bfx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execute core package
// Field widths, command codes, sequencer states and the count reduction.
// ----------------------------------------------------------------------------
package bfx_pkg;

   // Field widths
   localparam int CMD_W   = 4;
   localparam int COUNT_W = 16;
   localparam int BYTE_W  = 8;
   localparam int PC_W    = 17;

   // Default tape size
   localparam int unsigned TAPE_CELLS_DEF = 32768;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN     = 4'd0,
      CMD_CLOSE    = 4'd1,
      CMD_RIGHT    = 4'd2,
      CMD_LEFT     = 4'd3,
      CMD_ADD      = 4'd4,
      CMD_SUB      = 4'd5,
      CMD_CLEAR    = 4'd6,
      CMD_ADDRIGHT = 4'd7,
      CMD_LEFTDEC  = 4'd8,
      CMD_ADDLEFT  = 4'd9,
      CMD_PRINT    = 4'd10,
      CMD_READ     = 4'd11
   } cmd_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_APPLY
   } state_type;

   // Reduce a 16-bit count modulo the tape size. The tape has at least 256
   // cells, so the quotient fits in 8 bits: one conditional subtract per bit.
   function automatic logic [COUNT_W-1:0] count_mod(logic [COUNT_W-1:0] c,
                                                    int unsigned cells);
      logic [31:0] x;
      logic [31:0] d;
      x = {16'b0, c};
      for (int k = 7; k >= 0; k--) begin
         d = 32'(cells) << k;
         if (x >= d) begin
            x = x - d;
         end
      end
      return x[COUNT_W-1:0];
   endfunction

endpackage

// ===== rtl/brainfuck_execute_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brainfuck execute core
// Applies one decoded, run-length-compressed instruction per item to a byte
// tape and returns the program-counter step and an optional output byte.
// ----------------------------------------------------------------------------
// After reset the core sweeps the tape to zero, one cell per clock, and
// takes no item until the sweep is done. The tape is a single synchronous
// memory with one read and one write port; each item spends a read state
// on its memory read and an apply state on the modify and write-back, and
// the apply state waits while the output register holds an untaken result.
// The current cell is cached in a register, so branch tests, print and
// in-place cell updates do not touch the memory; pointer moves write the
// cached cell back and load the new one, and move-add reads the neighbor
// cell and writes the sum back. A result sits in an output register, so
// the next item is taken while that result still waits.
// ----------------------------------------------------------------------------

`include "brainfuck_execute_core_assert.svh"

module brainfuck_execute_core #(
   parameter int unsigned TAPE_CELLS = bfx_pkg::TAPE_CELLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Instruction channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bfx_pkg::CMD_W-1:0]         req_cmd,
   input  logic [bfx_pkg::COUNT_W-1:0]       req_count,
   input  logic [bfx_pkg::BYTE_W-1:0]        req_in_byte,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bfx_pkg::PC_W-1:0]   rsp_pc_step,
   output logic                              rsp_out_valid,
   output logic [bfx_pkg::BYTE_W-1:0]        rsp_out_byte
);

   import bfx_pkg::*;

   localparam int PTR_W = $clog2(TAPE_CELLS);
   localparam int PW1   = PTR_W + 1;
   localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_CELLS - 1);
   localparam logic [PW1-1:0]   CELLS_X   = PW1'(TAPE_CELLS);

   // Tape memory
   logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];

   // Sequencer
   state_type state_ff, state_in;
   logic [PTR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // Item held in the execute stage
   logic [CMD_W-1:0]   x_cmd_ff;
   logic [COUNT_W-1:0] x_count_ff;
   logic [PTR_W-1:0]   x_rcnt_ff;
   logic [BYTE_W-1:0]  x_in_byte_ff;

   // Architectural state: pointer and cached current cell
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [BYTE_W-1:0] cur_ff, cur_in;

   // Neighbor address and memory read data
   logic [PTR_W-1:0]  nb_ff, nb_in;
   logic [BYTE_W-1:0] rd_ff;

   // Memory port controls
   logic              mem_we;
   logic [PTR_W-1:0]  mem_wa;
   logic [BYTE_W-1:0] mem_wd;
   logic              mem_re;
   logic [PTR_W-1:0]  mem_ra;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [PC_W-1:0]  rsp_pc_step_ff;
   logic                    rsp_out_valid_ff;
   logic [BYTE_W-1:0]       rsp_out_byte_ff;
   logic [PC_W-1:0]         pc_step;
   logic                    out_flag;

   logic       accept;
   logic       finish;
   logic       x_move;
   cmd_type    x_cmd;

   logic [PTR_W-1:0] p_inc, p_dec, p_right, p_left;
   logic [PW1-1:0]   sum_x, dif_x, right_x, left_x;
   logic [PC_W-1:0]  cnt_x;

   assign x_cmd   = cmd_type'(x_cmd_ff);
   assign x_move  = (x_rcnt_ff != '0);
   assign finish  = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || finish;
   assign accept  = req_valid && req_ready;

   // Neighbor and moved pointer, wrapped modulo the tape size
   always_comb begin
      p_inc   = (ptr_ff == LAST_CELL) ? '0 : ptr_ff + PTR_W'(1);
      p_dec   = (ptr_ff == '0) ? LAST_CELL : ptr_ff - PTR_W'(1);
      sum_x   = {1'b0, ptr_ff} + {1'b0, x_rcnt_ff};
      right_x = (sum_x >= CELLS_X) ? sum_x - CELLS_X : sum_x;
      dif_x   = {1'b0, ptr_ff} - {1'b0, x_rcnt_ff};
      left_x  = dif_x[PTR_W] ? dif_x + CELLS_X : dif_x;
      p_right = right_x[PTR_W-1:0];
      p_left  = left_x[PTR_W-1:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (finish) begin
               state_in = accept ? ST_READ : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: memory ports, pointer, cached cell, result
   always_comb begin
      mem_we     = 1'b0;
      mem_wa     = ptr_ff;
      mem_wd     = cur_ff;
      mem_re     = 1'b0;
      mem_ra     = p_inc;
      ptr_in     = ptr_ff;
      cur_in     = cur_ff;
      nb_in      = nb_ff;
      clr_cnt_in = clr_cnt_ff;
      cnt_x      = {1'b0, x_count_ff};
      pc_step    = PC_W'(1);
      out_flag   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one cell per cycle
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = '0;
            clr_cnt_in = clr_cnt_ff + PTR_W'(1);
         end
         ST_IDLE: begin
         end
         ST_READ: begin
            // On a pointer move write back the cached cell; fetch the cell the item needs
            unique case (x_cmd)
               CMD_RIGHT: begin
                  if (x_move) begin
                     mem_we = 1'b1;
                     mem_re = 1'b1;
                     mem_ra = p_right;
                     ptr_in = p_right;
                  end
               end
               CMD_LEFT: begin
                  if (x_move) begin
                     mem_we = 1'b1;
                     mem_re = 1'b1;
                     mem_ra = p_left;
                     ptr_in = p_left;
                  end
               end
               CMD_LEFTDEC: begin
                  mem_we = 1'b1;
                  mem_re = 1'b1;
                  mem_ra = p_dec;
                  ptr_in = p_dec;
               end
               CMD_ADDRIGHT: begin
                  mem_re = 1'b1;
                  mem_ra = p_inc;
                  nb_in  = p_inc;
               end
               CMD_ADDLEFT: begin
                  mem_re = 1'b1;
                  mem_ra = p_dec;
                  nb_in  = p_dec;
               end
               default: begin
               end
            endcase
         end
         ST_APPLY: begin
            // Modify the cell and form the result; commit only on finish
            unique case (x_cmd)
               CMD_OPEN: begin
                  if (cur_ff == '0) begin
                     pc_step = cnt_x;
                  end
               end
               CMD_CLOSE: begin
                  if (cur_ff != '0) begin
                     pc_step = PC_W'(0) - cnt_x;
                  end
               end
               CMD_RIGHT, CMD_LEFT: begin
                  pc_step = cnt_x;
                  if (finish && x_move) begin
                     cur_in = rd_ff;
                  end
               end
               CMD_ADD: begin
                  pc_step = cnt_x;
                  if (finish) begin
                     cur_in = cur_ff + x_count_ff[BYTE_W-1:0];
                  end
               end
               CMD_SUB: begin
                  pc_step = cnt_x;
                  if (finish) begin
                     cur_in = cur_ff - x_count_ff[BYTE_W-1:0];
                  end
               end
               CMD_CLEAR: begin
                  if (finish) begin
                     cur_in = '0;
                  end
               end
               CMD_ADDRIGHT, CMD_ADDLEFT: begin
                  if (finish) begin
                     mem_we = 1'b1;
                     mem_wa = nb_ff;
                     mem_wd = rd_ff + cur_ff;
                     cur_in = '0;
                  end
               end
               CMD_LEFTDEC: begin
                  if (finish) begin
                     cur_in = rd_ff - BYTE_W'(1);
                  end
               end
               CMD_PRINT: begin
                  out_flag = 1'b1;
               end
               CMD_READ: begin
                  if (finish) begin
                     cur_in = x_in_byte_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Hold a result until taken, load a new one on finish
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ptr_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ptr_ff       <= ptr_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the item and reduce its count modulo the tape size
   always_ff @(posedge clock) begin
      if (accept) begin
         x_cmd_ff     <= req_cmd;
         x_count_ff   <= req_count;
         x_rcnt_ff    <= PTR_W'(count_mod(req_count, TAPE_CELLS));
         x_in_byte_ff <= req_in_byte;
      end
      nb_ff <= nb_in;
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_pc_step_ff   <= $signed(pc_step);
         rsp_out_valid_ff <= out_flag;
         rsp_out_byte_ff  <= out_flag ? cur_ff : '0;
      end
   end

   // Tape memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= tape_mem[mem_ra];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pc_step   = rsp_pc_step_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;

   // Checks
   `BFX_ASSERT_IMP(a_no_accept_in_clear, clock, reset, (state_ff == ST_CLEAR), !req_ready)
   `BFX_ASSERT_IMP(a_read_not_cached, clock, reset, mem_re, (mem_ra != ptr_ff))
   `BFX_ASSERT_IMP(a_apply_write_not_cached, clock, reset,
                   (mem_we && (state_ff == ST_APPLY)), (mem_wa != ptr_ff))
   `BFX_ASSERT_NXT(a_accept_starts_read, clock, reset, accept, (state_ff == ST_READ))
   `BFX_ASSERT_IMP(a_ptr_in_range, clock, reset, 1'b1, ({1'b0, ptr_ff} < CELLS_X))

endmodule

// ===== dv/tb_brainfuck_execute_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Brainfuck execute core
// Drives decoded instructions into the core, predicts each program-counter
// step and output byte from a private copy of the tape and cell pointer,
// and checks every returned item in order. Directed cases cover branch
// tests, tape-end wrap of the pointer and neighbor cells, count extremes
// and unused codes. Random traffic then runs under several idle patterns.
// ----------------------------------------------------------------------------

module tb_brainfuck_execute_core;
   import bfx_pkg::*;

   localparam int unsigned TAPE_CELLS     = TAPE_CELLS_DEF;
   localparam int          WATCHDOG_LIMIT = 200000;
   localparam int          DRAIN_CYCLES   = 8;

   // Codes the core does not decode
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd12;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

   typedef struct {
      logic signed [PC_W-1:0] pc_step;
      logic                   out_valid;
      logic [BYTE_W-1:0]      out_byte;
   } step_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [CMD_W-1:0]              req_cmd = '0;
   logic [COUNT_W-1:0]            req_count = '0;
   logic [BYTE_W-1:0]             req_in_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [PC_W-1:0]        rsp_pc_step;
   logic                          rsp_out_valid;
   logic [BYTE_W-1:0]             rsp_out_byte;

   // Private copy of the machine state
   logic [BYTE_W-1:0] tape_model [TAPE_CELLS];
   int unsigned       cell_ptr_model;

   step_result_type expected_steps [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int items_sent     = 0;
   int steps_checked  = 0;
   int bytes_printed  = 0;
   int branches_taken = 0;
   int quiet_cycles   = 0;

   brainfuck_execute_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_count     (req_count),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pc_step   (rsp_pc_step),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Clear the tape copy and home the pointer
   task automatic clear_tape_model();
      for (int i = 0; i < TAPE_CELLS; i++) begin
         tape_model[i] = '0;
      end
      cell_ptr_model = 0;
   endtask

   // Apply one instruction to the tape copy and queue the step it yields
   task automatic execute_model(input logic [CMD_W-1:0] cmd,
                                input logic [COUNT_W-1:0] count,
                                input logic [BYTE_W-1:0] in_byte);
      int unsigned     p;
      int unsigned     q;
      logic [PC_W-1:0] step;
      step_result_type res;
      p             = cell_ptr_model;
      step          = 17'd1;
      res.out_valid = 1'b0;
      res.out_byte  = '0;
      case (cmd)
         CMD_OPEN: begin
            if (tape_model[p] == 0) begin
               step = {1'b0, count};
               branches_taken++;
            end
         end
         CMD_CLOSE: begin
            if (tape_model[p] != 0) begin
               step = 17'd0 - {1'b0, count};
               branches_taken++;
            end
         end
         CMD_RIGHT: begin
            p    = (p + count % TAPE_CELLS) % TAPE_CELLS;
            step = {1'b0, count};
         end
         CMD_LEFT: begin
            p    = (p + TAPE_CELLS - count % TAPE_CELLS) % TAPE_CELLS;
            step = {1'b0, count};
         end
         CMD_ADD: begin
            tape_model[p] = tape_model[p] + count[BYTE_W-1:0];
            step          = {1'b0, count};
         end
         CMD_SUB: begin
            tape_model[p] = tape_model[p] - count[BYTE_W-1:0];
            step          = {1'b0, count};
         end
         CMD_CLEAR: begin
            tape_model[p] = '0;
         end
         CMD_ADDRIGHT: begin
            q             = (p + 1) % TAPE_CELLS;
            tape_model[q] = tape_model[q] + tape_model[p];
            tape_model[p] = '0;
         end
         CMD_LEFTDEC: begin
            p             = (p + TAPE_CELLS - 1) % TAPE_CELLS;
            tape_model[p] = tape_model[p] - 8'd1;
         end
         CMD_ADDLEFT: begin
            q             = (p + TAPE_CELLS - 1) % TAPE_CELLS;
            tape_model[q] = tape_model[q] + tape_model[p];
            tape_model[p] = '0;
         end
         CMD_PRINT: begin
            res.out_valid = 1'b1;
            res.out_byte  = tape_model[p];
         end
         CMD_READ: begin
            tape_model[p] = in_byte;
         end
         default: begin
         end
      endcase
      cell_ptr_model = p;
      res.pc_step    = step;
      expected_steps.push_back(res);
   endtask

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Send one item: idle at random first, then hold it until accepted
   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic [COUNT_W-1:0] count,
                            input logic [BYTE_W-1:0] in_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_count   <= count;
      req_in_byte <= in_byte;
      do begin
         @(posedge clock);
      end while (!req_ready);
      execute_model(cmd, count, in_byte);
      items_sent++;
   endtask

   // Randomize the receiver's ready each cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_steps.size() == 0) begin
            report_mismatch("unexpected result, pc_step", int'(rsp_pc_step), 0);
         end else begin
            want = expected_steps.pop_front();
            steps_checked++;
            if (rsp_out_valid) bytes_printed++;
            if (rsp_pc_step !== want.pc_step)
               report_mismatch("pc_step", int'(rsp_pc_step), int'(want.pc_step));
            if (rsp_out_valid !== want.out_valid)
               report_mismatch("out_valid", int'(rsp_out_valid), int'(want.out_valid));
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(rsp_out_byte), int'(want.out_byte));
         end
      end
   end

   // Abort when nothing moves for too long (covers the tape sweep after reset)
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("tb_brainfuck_execute_core NOT OK");
            $finish;
         end
      end
   end

   // Loop tests on zero and nonzero cells, including zero and full distances
   task automatic test_branches();
      send_item(CMD_READ, 16'd1, 8'hFF);
      send_item(CMD_PRINT, 16'd1, 8'h00);
      send_item(CMD_OPEN, 16'd5, 8'h00);
      send_item(CMD_CLOSE, 16'hFFFF, 8'h00);
      send_item(CMD_CLOSE, 16'd0, 8'h00);
      send_item(CMD_CLEAR, 16'd1, 8'h00);
      send_item(CMD_OPEN, 16'd0, 8'h00);
      send_item(CMD_OPEN, 16'hFFFF, 8'h00);
      send_item(CMD_CLOSE, 16'd7, 8'h00);
   endtask

   // Pointer and neighbor wrap at both ends of the tape
   task automatic test_tape_ends();
      send_item(CMD_LEFT, 16'd1, 8'h00);
      send_item(CMD_READ, 16'd1, 8'hAA);
      send_item(CMD_ADDRIGHT, 16'd1, 8'h00);
      send_item(CMD_RIGHT, 16'd1, 8'h00);
      send_item(CMD_PRINT, 16'd1, 8'h00);
      send_item(CMD_ADDLEFT, 16'd1, 8'h00);
      send_item(CMD_LEFTDEC, 16'd1, 8'h00);
      send_item(CMD_PRINT, 16'd1, 8'h00);
   endtask

   // Count extremes on moves and adds
   task automatic test_counts();
      send_item(CMD_ADD, 16'hFFFF, 8'h00);
      send_item(CMD_SUB, 16'h0101, 8'h00);
      send_item(CMD_ADD, 16'd0, 8'h00);
      send_item(CMD_RIGHT, 16'd0, 8'h00);
      send_item(CMD_LEFT, 16'd0, 8'h00);
      send_item(CMD_RIGHT, 16'hFFFF, 8'h00);
      send_item(CMD_LEFT, 16'd40000, 8'h00);
      send_item(CMD_PRINT, 16'd1, 8'h00);
   endtask

   // Codes outside the command set leave the state alone
   task automatic test_unused_codes();
      for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
         send_item(CMD_W'(c), 16'(($urandom)), 8'($urandom));
      end
      send_item(CMD_PRINT, 16'd1, 8'h00);
   endtask

   // Random instructions under one idle pattern
   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      int                 sel;
      logic [CMD_W-1:0]   cmd;
      logic [COUNT_W-1:0] count;
      logic [BYTE_W-1:0]  in_byte;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(99);
         if (sel < 8) cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
         else         cmd = CMD_W'($urandom_range(CMD_READ, CMD_OPEN));
         // keep most counts short so the pointer stays near written cells
         sel = $urandom_range(99);
         if (sel < 45)      count = COUNT_W'($urandom_range(9, 0));
         else if (sel < 70) count = COUNT_W'($urandom_range(255, 0));
         else if (sel < 85) count = COUNT_W'($urandom);
         else               count = 16'd1;
         sel = $urandom_range(99);
         if (sel < 10)      in_byte = 8'hFF;
         else if (sel < 15) in_byte = 8'h00;
         else               in_byte = BYTE_W'($urandom);
         send_item(cmd, count, in_byte);
      end
   endtask

   initial begin
      clear_tape_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_branches();
      test_tape_ends();
      test_counts();
      test_unused_codes();

      test_random_traffic(400, 0, 0);
      test_random_traffic(320, 83, 0);
      test_random_traffic(320, 0, 83);
      test_random_traffic(310, 27, 27);
      req_valid <= 1'b0;

      // drain outstanding results, then watch for strays
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d instructions, checked %0d steps", items_sent, steps_checked);
      $display("printed bytes %0d, taken branches %0d, mismatches %0d",
               bytes_printed, branches_taken, error_count);
      if (error_count == 0) begin
         $display("tb_brainfuck_execute_core OK");
      end else begin
         $display("tb_brainfuck_execute_core NOT OK");
      end
      $finish;
   end

endmodule
